### design/iee_pkg.sv
// Shared types and constants of the integer expression evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none
package iee_pkg;

    // Defaults of the top level parameters
    localparam int DEF_NEST_DEPTH = 32;
    localparam int DEF_WORD_BITS  = 64;

    // Fixed width of the value field on the result stream
    localparam int VALUE_BITS = 64;

    // Pending multiplicative operator
    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } t_mulop;

    // Request from the parser to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic div;
    } t_md_req;

endpackage
`default_nettype wire

### design/iee_stack.sv
// Frame stack of the evaluator: one saved outer level per open parenthesis.
// Single write port, single read port with registered read data. Uses iee_pkg.
`default_nettype none
module iee_stack
    import iee_pkg::*;
#(
    parameter int DEPTH = DEF_NEST_DEPTH,
    parameter int WIDTH = 2 * DEF_WORD_BITS + 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### design/iee_muldiv.sv
// Bit-serial multiply (low word) and signed truncating divide, one bit per cycle.
// Divide by zero gives zero. Uses iee_pkg for the request struct.
`default_nettype none
module iee_muldiv
    import iee_pkg::*;
#(
    parameter int W = DEF_WORD_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_md_req      i_req,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic      [W-1:0] o_result
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_FIN
    } t_mstate;

    t_mstate        r_state;
    logic [CW-1:0]  r_cnt;
    logic           r_div;
    logic           r_neg;
    logic           r_bzero;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_m;
    logic [W-1:0]   r_q;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_res;
    logic           r_done;

    logic [W-1:0]   abs_a;
    logic [W-1:0]   abs_b;
    logic [W+1:0]   n_shift;
    logic [W+1:0]   n_trial;
    logic [W-1:0]   n_quo;

    // magnitudes for the divide setup
    assign abs_a = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign abs_b = i_b[W-1] ? (~i_b + W'(1)) : i_b;

    // one restoring step
    assign n_shift = {1'b0, r_rem, r_q[W-1]};
    assign n_trial = n_shift - {2'b00, r_m};
    assign n_quo   = r_neg ? (~r_q + W'(1)) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_div   <= i_req.div;
                        r_cnt   <= CW'(W - 1);
                        r_acc   <= '0;
                        r_rem   <= '0;
                        r_neg   <= i_a[W-1] ^ i_b[W-1];
                        r_bzero <= (i_b == '0);
                        r_m     <= i_req.div ? abs_b : i_a;
                        r_q     <= i_req.div ? abs_a : i_b;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (r_div) begin
                        if (!n_trial[W+1]) begin
                            r_rem <= n_trial[W-1:0];
                        end else begin
                            r_rem <= n_shift[W-1:0];
                        end
                        r_q <= {r_q[W-2:0], ~n_trial[W+1]};
                    end else begin
                        if (r_q[0]) begin
                            r_acc <= r_acc + r_m;
                        end
                        r_m <= r_m << 1;
                        r_q <= r_q >> 1;
                    end
                    if (r_cnt == '0) begin
                        r_state <= M_FIN;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                M_FIN: begin
                    if (r_div) begin
                        r_res <= r_bzero ? '0 : n_quo;
                    end else begin
                        r_res <= r_acc;
                    end
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

### design/integer_expression_evaluator_core.sv
// Top level of the infix integer expression evaluator.
// Depends on iee_pkg, iee_stack and iee_muldiv.
//
// Usage: characters of a line enter on the s_axis channel (tdata = char_code,
// tuser = line_end). A transaction with tuser high ends the line; one result
// then leaves on the m_axis channel (tdata = value, tuser = nest_overflow).
// Each item is handled alone: tready is high only while the parser waits.
// Per character: a digit, sign, blank or '(' goes through the feed state and
// back to idle; a character that closes a number or an empty operand first
// has the operand placed, then the character is fed again; when a * or /
// waits, placing the operand goes through the serial multiply/divide
// unit, the only slow unit in the block.
// A ')' restores the outer level and places the inner value, through the
// unit when a * or / waits outside.
// Line end: each still open level is closed in turn, with a pass through
// the unit for each pending * or /, before the result is valid.
// The result stays on m_axis until taken; no input is taken meanwhile.
// Synchronous active-low reset returns the parser to the start of a line;
// the frame stack needs no clearing since only pushed entries are read.
`default_nettype none
module integer_expression_evaluator_core
    import iee_pkg::*;
#(
    parameter int NEST_DEPTH = DEF_NEST_DEPTH,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [7:0]            i_s_axis_tdata,   // [7:0] char_code
    input  wire logic                  i_s_axis_tuser,   // [0] line_end
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [VALUE_BITS-1:0] o_m_axis_tdata,   // [63:0] value
    output logic                       o_m_axis_tuser    // [0] nest_overflow
);

    localparam int W  = WORD_BITS;
    localparam int LW = $clog2(NEST_DEPTH + 1);
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int FW = 2 * W + 4;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        POS_OPERAND,
        POS_NUMBER,
        POS_AFTER
    } t_pos;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_PUT,
        S_MD,
        S_POP,
        S_END,
        S_OUT
    } t_state;

    // where to go once an operand is placed
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_FEED,
        RET_END
    } t_ret;

    t_state           r_state;
    t_ret             r_ret;
    t_pos             r_pos;
    t_mulop           r_op;
    logic [7:0]       r_char;
    logic [W-1:0]     r_sum;
    logic [W-1:0]     r_prod;
    logic [W-1:0]     r_num;
    logic [W-1:0]     r_opnd;
    logic             r_addneg;
    logic             r_parity;
    logic [LW-1:0]    r_level;
    logic             r_fin;
    logic             r_ovf;
    logic [VALUE_BITS-1:0] r_out_val;
    logic             r_out_ovf;

    logic [W-1:0]     close_sum;
    logic [W-1:0]     signed_opnd;
    logic [W-1:0]     num_next;
    logic             c_blank;
    logic             c_digit;
    logic [LW-1:0]    level_m1;
    logic             push_en;
    logic             pop_en;
    logic [FW-1:0]    push_frame;
    logic [FW-1:0]    pop_frame;
    t_md_req          md_req;
    logic             md_done;
    logic [W-1:0]     md_result;

    // character classes
    assign c_blank = (r_char == CH_SPACE) || ((r_char >= CH_TAB) && (r_char <= CH_CR));
    assign c_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);

    // datapath: level sum, operand sign, decimal digit step, level decrement
    assign close_sum   = r_sum + (r_addneg ? ~r_prod : r_prod) + W'(r_addneg);
    assign signed_opnd = r_parity ? (~r_opnd + W'(1)) : r_opnd;
    assign num_next    = (r_num << 3) + (r_num << 1) + W'(r_char[3:0]);
    assign level_m1    = r_level - LW'(1);

    // stack access
    assign push_en = (r_state == S_FEED) && (r_pos == POS_OPERAND)
                     && (r_char == CH_LPAREN) && (r_level < LW'(NEST_DEPTH));
    assign pop_en  = ((r_state == S_FEED) && (r_pos == POS_AFTER) && !c_blank
                      && (r_char == CH_RPAREN) && (r_level != '0))
                  || ((r_state == S_END) && (r_pos == POS_AFTER) && (r_level != '0));
    assign push_frame = {r_sum, r_prod, r_addneg, r_op, r_parity};

    iee_stack #(
        .DEPTH (NEST_DEPTH),
        .WIDTH (FW),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (push_en),
        .i_wr_addr (r_level[AW-1:0]),
        .i_wr_data (push_frame),
        .i_rd_en   (pop_en),
        .i_rd_addr (level_m1[AW-1:0]),
        .o_rd_data (pop_frame)
    );

    // serial multiply/divide
    assign md_req.start = (r_state == S_PUT) && (r_op != OP_NONE);
    assign md_req.div   = (r_op == OP_DIV);

    iee_muldiv #(
        .W (W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (r_prod),
        .i_b      (signed_opnd),
        .o_done   (md_done),
        .o_result (md_result)
    );

    // parser state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= RET_IDLE;
            r_pos    <= POS_OPERAND;
            r_op     <= OP_NONE;
            r_sum    <= '0;
            r_prod   <= '0;
            r_num    <= '0;
            r_addneg <= 1'b0;
            r_parity <= 1'b0;
            r_level  <= '0;
            r_fin    <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_char <= i_s_axis_tdata;
                        if (i_s_axis_tuser) begin
                            r_state <= S_END;
                        end else if (!r_fin) begin
                            r_state <= S_FEED;
                        end
                    end
                end
                S_FEED: begin
                    r_state <= S_IDLE;
                    unique case (r_pos)
                        POS_NUMBER: begin
                            if (c_digit) begin
                                r_num <= num_next;
                            end else begin
                                r_opnd  <= r_num;
                                r_ret   <= RET_FEED;
                                r_state <= S_PUT;
                            end
                        end
                        POS_OPERAND: begin
                            priority if (c_blank || r_char == CH_PLUS) begin
                            end else if (r_char == CH_MINUS) begin
                                r_parity <= ~r_parity;
                            end else if (c_digit) begin
                                r_num <= W'(r_char[3:0]);
                                r_pos <= POS_NUMBER;
                            end else if (r_char == CH_LPAREN) begin
                                if (r_level >= LW'(NEST_DEPTH)) begin
                                    r_ovf <= 1'b1;
                                    r_fin <= 1'b1;
                                end else begin
                                    r_level  <= r_level + LW'(1);
                                    r_sum    <= '0;
                                    r_prod   <= '0;
                                    r_addneg <= 1'b0;
                                    r_op     <= OP_NONE;
                                    r_parity <= 1'b0;
                                end
                            end else begin
                                r_opnd  <= '0;
                                r_ret   <= RET_FEED;
                                r_state <= S_PUT;
                            end
                        end
                        default: begin
                            priority if (c_blank) begin
                            end else if (r_char == CH_STAR || r_char == CH_SLASH) begin
                                r_op  <= (r_char == CH_STAR) ? OP_MUL : OP_DIV;
                                r_pos <= POS_OPERAND;
                            end else if (r_char == CH_PLUS || r_char == CH_MINUS) begin
                                r_sum    <= close_sum;
                                r_addneg <= (r_char == CH_MINUS);
                                r_pos    <= POS_OPERAND;
                            end else if (pop_en) begin
                                r_opnd  <= close_sum;
                                r_level <= level_m1;
                                r_ret   <= RET_IDLE;
                                r_state <= S_POP;
                            end else begin
                                r_fin <= 1'b1;
                            end
                        end
                    endcase
                end
                S_POP: begin
                    // restore the outer level, then place the inner value
                    {r_sum, r_prod, r_addneg} <= pop_frame[FW-1:3];
                    r_op     <= t_mulop'(pop_frame[2:1]);
                    r_parity <= pop_frame[0];
                    r_state  <= S_PUT;
                end
                S_PUT: begin
                    if (r_op == OP_NONE) begin
                        r_prod   <= signed_opnd;
                        r_parity <= 1'b0;
                        r_pos    <= POS_AFTER;
                        unique case (r_ret)
                            RET_FEED: r_state <= S_FEED;
                            RET_END:  r_state <= S_END;
                            default:  r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_state <= S_MD;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        r_prod   <= md_result;
                        r_op     <= OP_NONE;
                        r_parity <= 1'b0;
                        r_pos    <= POS_AFTER;
                        unique case (r_ret)
                            RET_FEED: r_state <= S_FEED;
                            RET_END:  r_state <= S_END;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_END: begin
                    r_ret <= RET_END;
                    unique case (r_pos)
                        POS_NUMBER: begin
                            r_opnd  <= r_num;
                            r_state <= S_PUT;
                        end
                        POS_OPERAND: begin
                            r_opnd  <= '0;
                            r_state <= S_PUT;
                        end
                        default: begin
                            if (pop_en) begin
                                r_opnd  <= close_sum;
                                r_level <= level_m1;
                                r_state <= S_POP;
                            end else begin
                                r_out_val <= VALUE_BITS'(signed'(close_sum));
                                r_out_ovf <= r_ovf;
                                r_pos     <= POS_OPERAND;
                                r_op      <= OP_NONE;
                                r_sum     <= '0;
                                r_prod    <= '0;
                                r_num     <= '0;
                                r_addneg  <= 1'b0;
                                r_parity  <= 1'b0;
                                r_level   <= '0;
                                r_fin     <= 1'b0;
                                r_ovf     <= 1'b0;
                                r_state   <= S_OUT;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = r_out_ovf;

endmodule
`default_nettype wire

### design/iee_checker.sv
// Port-level checks of the expression evaluator, bound to the top level.
// Uses iee_pkg for the result width.
`default_nettype none
module iee_checker
    import iee_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [VALUE_BITS-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tuser
);

    // input is never taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("input ready while result pending");

    // after a result transaction the parser is ready again
    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> o_s_axis_tready)
        else $error("not ready after result transaction");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind integer_expression_evaluator_core iee_checker u_iee_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

### verif/integer_expression_evaluator_core_tb.sv
// Self-checking testbench of the infix integer expression evaluator core.
// Depends on iee_pkg and integer_expression_evaluator_core; drives character lines
// with random gaps and stalls, predicts each line value and compares field by field.
`timescale 1ns / 100ps
module integer_expression_evaluator_core_tb;
    import iee_pkg::*;

    localparam int DEPTH = DEF_NEST_DEPTH;
    localparam int CYCLE_LIMIT = 4000000;

    typedef enum logic [1:0] {
        POS_OPERAND,
        POS_NUMBER,
        POS_AFTER
    } t_pos;

    typedef struct packed {
        logic [7:0] code;
        logic       eol;
    } t_char;

    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
    } t_line_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] char_code
    logic        i_s_axis_tuser;   // [0] line_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [63:0] value
    logic        o_m_axis_tuser;   // [0] nest_overflow

    integer_expression_evaluator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Evaluator shadow state
    logic [63:0] ev_stk_sum [DEPTH];
    logic [63:0] ev_stk_prod[DEPTH];
    logic        ev_stk_neg [DEPTH];
    t_mulop      ev_stk_op  [DEPTH];
    logic        ev_stk_par [DEPTH];
    logic [63:0] ev_sum, ev_prod, ev_num;
    logic        ev_neg, ev_par, ev_done, ev_ovf;
    t_mulop      ev_op;
    t_pos        ev_pos;
    int          ev_level;

    t_char        char_queue[$];
    t_line_result line_values[$];
    int           error_count = 0;
    longint       cycle_count = 0;
    bit           stim_done = 0;

    // Character classes
    function automatic bit is_blank(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Signed divide, truncating, zero divisor gives zero
    function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
        logic [63:0] ua, ub, q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        if (ub == 0) return 64'd0;
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] level_sum();
        return ev_neg ? ev_sum - ev_prod : ev_sum + ev_prod;
    endfunction

    function automatic void apply_operand(logic [63:0] x);
        if (ev_par) x = -x;
        ev_par = 0;
        case (ev_op)
            OP_MUL: ev_prod = ev_prod * x;
            OP_DIV: ev_prod = div_trunc(ev_prod, x);
            default: ev_prod = x;
        endcase
        ev_op = OP_NONE;
        ev_pos = POS_AFTER;
    endfunction

    function automatic void close_level();
        logic [63:0] v;
        v = level_sum();
        ev_level--;
        ev_sum  = ev_stk_sum[ev_level];
        ev_prod = ev_stk_prod[ev_level];
        ev_neg  = ev_stk_neg[ev_level];
        ev_op   = ev_stk_op[ev_level];
        ev_par  = ev_stk_par[ev_level];
        apply_operand(v);
    endfunction

    task automatic clear_line();
        ev_sum = 0; ev_prod = 0; ev_num = 0;
        ev_neg = 0; ev_par = 0; ev_done = 0; ev_ovf = 0;
        ev_op = OP_NONE; ev_pos = POS_OPERAND; ev_level = 0;
    endtask

    // One character; returns 1 when consumed
    function automatic bit eval_char(logic [7:0] c);
        case (ev_pos)
            POS_NUMBER: begin
                if (is_digit(c)) begin
                    ev_num = ev_num * 10 + 64'(c - "0");
                    return 1;
                end
                apply_operand(ev_num);
                return 0;
            end
            POS_OPERAND: begin
                if (is_blank(c) || c == "+") return 1;
                if (c == "-") begin
                    ev_par ^= 1;
                    return 1;
                end
                if (is_digit(c)) begin
                    ev_num = 64'(c - "0");
                    ev_pos = POS_NUMBER;
                    return 1;
                end
                if (c == "(") begin
                    if (ev_level >= DEPTH) begin
                        ev_ovf = 1;
                        ev_done = 1;
                        return 1;
                    end
                    ev_stk_sum[ev_level]  = ev_sum;
                    ev_stk_prod[ev_level] = ev_prod;
                    ev_stk_neg[ev_level]  = ev_neg;
                    ev_stk_op[ev_level]   = ev_op;
                    ev_stk_par[ev_level]  = ev_par;
                    ev_level++;
                    ev_sum = 0; ev_prod = 0; ev_neg = 0; ev_op = OP_NONE; ev_par = 0;
                    return 1;
                end
                apply_operand(64'd0);
                return 0;
            end
            default: begin
                if (is_blank(c)) return 1;
                if (c == "*" || c == "/") begin
                    ev_op = (c == "*") ? OP_MUL : OP_DIV;
                    ev_pos = POS_OPERAND;
                    return 1;
                end
                if (c == "+" || c == "-") begin
                    ev_sum = level_sum();
                    ev_neg = (c == "-");
                    ev_pos = POS_OPERAND;
                    return 1;
                end
                if (c == ")" && ev_level > 0) begin
                    close_level();
                    return 1;
                end
                ev_done = 1;
                return 1;
            end
        endcase
    endfunction

    // Predict one accepted transaction
    task automatic predict_char(t_char t);
        t_line_result r;
        if (!t.eol) begin
            for (int g = 0; g < 3 && !ev_done; g++)
                if (eval_char(t.code)) break;
            return;
        end
        if (ev_pos == POS_NUMBER) apply_operand(ev_num);
        else if (ev_pos == POS_OPERAND) apply_operand(64'd0);
        while (ev_level > 0) close_level();
        r.value = level_sum();
        r.ovf = ev_ovf;
        line_values.push_back(r);
        clear_line();
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Stimulus helpers
    task automatic push_text(string s);
        t_char t;
        for (int i = 0; i < s.len(); i++) begin
            t.code = s[i];
            t.eol = 0;
            char_queue.push_back(t);
        end
    endtask

    task automatic push_eol();
        t_char t;
        t.code = 8'($urandom);
        t.eol = 1;
        char_queue.push_back(t);
    endtask

    function automatic string rand_number();
        string s;
        int n;
        s = "";
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_blanks();
        string s;
        s = "";
        while ($urandom_range(0, 3) == 0)
            s = {s, string'(($urandom_range(0, 1) == 0) ? 8'd32 : 8'($urandom_range(9, 13)))};
        return s;
    endfunction

    // Random expression with depth bound, at times with an unclosed '(' or an empty operand
    function automatic string rand_expr(int depth_left);
        string s, ops;
        int n;
        ops = "+-*/";
        s = "";
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (i > 0) s = {s, rand_blanks(), string'(ops[$urandom_range(0, 3)]), rand_blanks()};
            while ($urandom_range(0, 4) == 0)
                s = {s, ($urandom_range(0, 1) == 0) ? "-" : "+"};
            if (depth_left > 0 && $urandom_range(0, 3) == 0)
                s = {s, "(", rand_expr(depth_left - 1), ($urandom_range(0, 7) == 0) ? "" : ")"};
            else if ($urandom_range(0, 15) != 0)
                s = {s, rand_number()};
        end
        return s;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset and stimulus
    initial begin
        string s;
        int items;
        i_rst_n = 0;
        clear_line();
        push_text("1+2*3"); push_eol();
        push_text("-(7-10)/ -2 * 3"); push_eol();
        push_text("9223372036854775807+1"); push_eol();
        push_text("-9223372036854775808/-1"); push_eol();
        push_text("5/0+ - -+-4"); push_eol();
        push_text("99999999999999999999999"); push_eol();
        push_text("((2+3)*4"); push_eol();
        push_text("1 2)+3"); push_eol();
        push_text("*+/"); push_eol();
        push_eol();
        push_text("7\t*\r(\n3\v-\f1)"); push_eol();
        s = "";
        for (int i = 0; i < DEPTH + 1; i++) s = {s, "("};
        push_text({s, "5"}); push_eol();
        s = "";
        for (int i = 0; i < DEPTH; i++) s = {s, "(2*"};
        push_text(s); push_eol();
        push_text({"3", string'(8'd200), "+4"}); push_eol();
        push_text({"6", string'(8'd255), string'(8'd0)}); push_eol();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        items = 0;
        while (items < 1950) begin
            int k;
            k = char_queue.size();
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(0, 12)) push_text(string'(8'($urandom)));
                end
                1: begin
                    s = "";
                    repeat ($urandom_range(25, 36)) s = {s, "("};
                    push_text({s, rand_expr(2)});
                end
                default: push_text(rand_expr(3));
            endcase
            push_eol();
            items += char_queue.size() - k;
        end
        stim_done = 1;
    end

    // Driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
            i_s_axis_tdata <= 0;
            i_s_axis_tuser <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) predict_char({i_s_axis_tdata, i_s_axis_tuser});
            if (send_gap > 0 || char_queue.size() == 0) begin
                i_s_axis_tvalid <= 0;
                if (send_gap > 0) send_gap--;
            end else begin
                t_char t;
                t = char_queue.pop_front();
                i_s_axis_tvalid <= 1;
                i_s_axis_tdata <= t.code;
                i_s_axis_tuser <= t.eol;
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
        end
    end

    // Monitor
    int recv_gap = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n) begin
            i_m_axis_tready <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (line_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
                end else begin
                    t_line_result r;
                    r = line_values.pop_front();
                    if (o_m_axis_tdata !== r.value)
                        report_mismatch($sformatf("value %h, predicted %h",
                                                  o_m_axis_tdata, r.value));
                    if (o_m_axis_tuser !== r.ovf)
                        report_mismatch($sformatf("nest_overflow %b, predicted %b",
                                                  o_m_axis_tuser, r.ovf));
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (recv_gap > 0) begin
                i_m_axis_tready <= 0;
                recv_gap--;
            end else begin
                i_m_axis_tready <= 1;
            end
        end
    end

    // End of run
    initial begin
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = 0;
        i_s_axis_tuser = 0;
        i_m_axis_tready = 0;
        fork
            begin
                wait (stim_done && char_queue.size() == 0 && !i_s_axis_tvalid
                      && line_values.size() == 0);
                repeat (3000) @(posedge i_clk);
                if (line_values.size() != 0) error_count++;
                if (error_count == 0) $display("TB_OK");
                else $display("TB_ERROR");
            end
            begin
                wait (cycle_count >= CYCLE_LIMIT);
                $display("TB_ERROR");
            end
        join_any
        $finish;
    end

endmodule

### sim.f
design/iee_pkg.sv
design/iee_stack.sv
design/iee_muldiv.sv
design/integer_expression_evaluator_core.sv
design/iee_checker.sv
verif/integer_expression_evaluator_core_tb.sv
